### design/ffha_pkg.sv
// Shared types and codes for the first-fit heap allocator.
// No dependencies; imported by the top and the APB register block.
package ffha_pkg;

    // Walk and update sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ALOC,
        S_SPLT,
        S_FIND,
        S_NEXT,
        S_OUT
    } t_state;

    // Result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_OOM  = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;
    localparam logic [1:0] STAT_NULL = 2'd3;

    // Request kinds
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_BYTES = 1'b1;

    localparam int HEAP_BYTES_W = 17;

    // Configuration handed from the register block to the sequencer
    typedef struct packed {
        logic [31:0]             heap_base;
        logic [HEAP_BYTES_W-1:0] heap_bytes;
        logic                    rebuild;   // one-cycle pulse: write first header
    } t_cfg;

endpackage

### design/first_fit_heap_allocator_top.sv
// First-fit heap allocator: the walk reads one header per cycle from the header RAM,
// which sets the rate. From acceptance, an allocate reads headers until a block fits
// or the heap ends, a split writing one more header; a free reads headers up to its block
// and, if found, writes the merged one; null, range-checked and empty-heap requests skip the walk.
// One request at a time; a finished result may wait in the output register while the next
// is taken. Reset is synchronous; during reset, the cycle after it and the cycle after each
// register write, an idle sequencer rewrites the first header if it fits, input stalled.
// Depends on ffha_pkg, ffha_hdr_ram, ffha_apb. The user must keep HEADER/ALIGN powers of two; not checked.
module first_fit_heap_allocator_top
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 16,
    parameter int ALIGN_BYTES  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // req_bytes[16:0], addr[48:17], zero fill
    input  logic [0:0]  s_tuser,   // cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // addr_out[31:0], status[33:32], zero fill
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int G     = (HEADER_BYTES < ALIGN_BYTES) ? HEADER_BYTES : ALIGN_BYTES;
    localparam int GB    = $clog2(G);
    localparam int DEPTH = HEAP_BYTES / G;
    localparam int IW    = $clog2(DEPTH);
    localparam int OFW   = $clog2(HEAP_BYTES + 1);
    localparam int XW    = ((OFW > 18) ? OFW : 18) + 2;
    localparam int DW    = OFW + 1;
    localparam int AB    = $clog2(ALIGN_BYTES);

    t_cfg cfg;

    ffha_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // header RAM: entry = {free, size in bytes}
    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [DW-1:0] mem_wdata, mem_rdata;

    ffha_hdr_ram #(.DEPTH(DEPTH), .IW(IW), .DW(DW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    t_state r_state, n_state;
    logic [XW-1:0] r_cur, n_cur, r_off, n_off, r_need, n_need;
    logic [XW-1:0] r_prv, n_prv, r_prv_size, n_prv_size, r_cur_size, n_cur_size;
    logic          r_prv_free, n_prv_free, r_has_prv, n_has_prv, r_nxt_ok, n_nxt_ok;
    logic [31:0]   r_res_addr, n_res_addr;
    logic [1:0]    r_res_stat, n_res_stat;
    logic          r_m_valid;
    logic [31:0]   r_m_addr;
    logic [1:0]    r_m_stat;

    logic [XW-1:0] eff, hdr_x, aln_x, rd_size, nxt, in_need, msize;
    logic          hvalid, rd_free, accept;
    logic [31:0]   in_addr, off32;
    logic [16:0]   in_req;

    assign hdr_x   = XW'(HEADER_BYTES);
    assign aln_x   = XW'(ALIGN_BYTES);
    assign eff     = (XW'(cfg.heap_bytes) > XW'(HEAP_BYTES)) ? XW'(HEAP_BYTES)
                                                             : XW'(cfg.heap_bytes);
    assign hvalid  = eff >= hdr_x;
    assign rd_size = XW'(mem_rdata[OFW-1:0]);
    assign rd_free = mem_rdata[OFW];
    assign nxt     = r_cur + hdr_x + rd_size;
    assign in_req  = s_tdata[16:0];
    assign in_addr = s_tdata[48:17];
    assign in_need = ((XW'(in_req) + aln_x - XW'(1)) >> AB) << AB;
    assign off32   = in_addr - cfg.heap_base - 32'(HEADER_BYTES);
    assign msize   = r_cur_size + ((r_nxt_ok && rd_free) ? (hdr_x + rd_size) : '0);

    assign s_tready = (r_state == S_IDLE) && !cfg.rebuild;
    assign accept   = s_tvalid && s_tready;

    // state and walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_off      <= n_off;
        r_need     <= n_need;
        r_prv      <= n_prv;
        r_prv_size <= n_prv_size;
        r_prv_free <= n_prv_free;
        r_has_prv  <= n_has_prv;
        r_cur_size <= n_cur_size;
        r_nxt_ok   <= n_nxt_ok;
        r_res_addr <= n_res_addr;
        r_res_stat <= n_res_stat;
    end

    // sequencer: walk the block chain one header per cycle
    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_off      = r_off;
        n_need     = r_need;
        n_prv      = r_prv;
        n_prv_size = r_prv_size;
        n_prv_free = r_prv_free;
        n_has_prv  = r_has_prv;
        n_cur_size = r_cur_size;
        n_nxt_ok   = r_nxt_ok;
        n_res_addr = r_res_addr;
        n_res_stat = r_res_stat;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (cfg.rebuild && hvalid) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = {1'b1, OFW'(eff - hdr_x)};
                end
                if (accept) begin
                    n_cur      = '0;
                    n_has_prv  = 1'b0;
                    n_need     = in_need;
                    n_off      = XW'(off32[OFW-1:0]);
                    n_res_addr = '0;
                    if (s_tuser[0] == CMD_ALLOC) begin
                        if (hvalid) begin
                            mem_re  = 1'b1;
                            n_state = S_ALOC;
                        end else begin
                            n_res_stat = STAT_OOM;
                            n_state    = S_OUT;
                        end
                    end else if (in_addr == '0) begin
                        n_res_stat = STAT_NULL;
                        n_state    = S_OUT;
                    end else if (!hvalid || off32 >= 32'(eff) || off32[GB-1:0] != '0) begin
                        n_res_stat = STAT_BAD;
                        n_state    = S_OUT;
                    end else begin
                        mem_re  = 1'b1;
                        n_state = S_FIND;
                    end
                end
            end

            S_ALOC: begin
                if (rd_free && rd_size >= r_need) begin
                    n_res_addr = cfg.heap_base + 32'(r_cur) + 32'(HEADER_BYTES);
                    n_res_stat = STAT_OK;
                    mem_we     = 1'b1;
                    if (rd_size >= r_need + hdr_x + aln_x) begin
                        // split: new free block after the allocated part
                        mem_waddr = IW'((r_cur + hdr_x + r_need) >> GB);
                        mem_wdata = {1'b1, OFW'(rd_size - r_need - hdr_x)};
                        n_state   = S_SPLT;
                    end else begin
                        mem_waddr = IW'(r_cur >> GB);
                        mem_wdata = {1'b0, OFW'(rd_size)};
                        n_state   = S_OUT;
                    end
                end else if (nxt >= eff) begin
                    n_res_stat = STAT_OOM;
                    n_state    = S_OUT;
                end else begin
                    n_cur     = nxt;
                    mem_re    = 1'b1;
                    mem_raddr = IW'(nxt >> GB);
                end
            end

            S_SPLT: begin
                mem_we    = 1'b1;
                mem_waddr = IW'(r_cur >> GB);
                mem_wdata = {1'b0, OFW'(r_need)};
                n_state   = S_OUT;
            end

            S_FIND: begin
                priority if (r_cur == r_off) begin
                    n_cur_size = rd_size;
                    n_nxt_ok   = nxt < eff;
                    mem_re     = nxt < eff;
                    mem_raddr  = IW'(nxt >> GB);
                    n_state    = S_NEXT;
                end else if (r_cur > r_off || nxt >= eff) begin
                    n_res_stat = STAT_BAD;
                    n_state    = S_OUT;
                end else begin
                    n_prv      = r_cur;
                    n_prv_size = rd_size;
                    n_prv_free = rd_free;
                    n_has_prv  = 1'b1;
                    n_cur      = nxt;
                    mem_re     = 1'b1;
                    mem_raddr  = IW'(nxt >> GB);
                end
            end

            S_NEXT: begin
                // merge with a free next block, then with a free previous one
                mem_we     = 1'b1;
                n_res_stat = STAT_OK;
                if (r_has_prv && r_prv_free) begin
                    mem_waddr = IW'(r_prv >> GB);
                    mem_wdata = {1'b1, OFW'(r_prv_size + hdr_x + msize)};
                end else begin
                    mem_waddr = IW'(r_cur >> GB);
                    mem_wdata = {1'b1, OFW'(msize)};
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                if (!r_m_valid || m_tready) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_OUT && (!r_m_valid || m_tready)) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_m_valid || m_tready)) begin
            r_m_addr <= r_res_addr;
            r_m_stat <= r_res_stat;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {6'b0, r_m_stat, r_m_addr};

    // checks
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !cfg.rebuild) |-> !mem_we)
        else $error("header write while idle");

    a_split_after_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLT) |-> ($past(r_state) == S_ALOC))
        else $error("split write without alloc hit");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer idle");

    a_no_accept_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg.rebuild |-> !s_tready)
        else $error("request taken during rebuild");

    a_ok_free_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT) |=> (r_res_addr == '0 && r_res_stat == STAT_OK))
        else $error("free result carries an address");

endmodule

### design/ffha_hdr_ram.sv
// Header store: simple dual-port RAM, one write and one registered read port.
// Depends on nothing but its parameters.
module ffha_hdr_ram #(
    parameter int DEPTH = 8192,
    parameter int IW    = 13,
    parameter int DW    = 18
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [IW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/ffha_apb.sv
// APB register block: heap_base and heap_bytes, rebuild pulse on any write.
// Depends on ffha_pkg.
module ffha_apb
    import ffha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [31:0]             r_heap_base;
    logic [HEAP_BYTES_W-1:0] r_heap_bytes;
    logic                    r_rebuild;
    logic                    wr_hit;

    assign wr_hit = psel && penable && pwrite;
    assign pready = 1'b1;

    // registers; rebuild fires after reset and after every write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= '0;
            r_heap_bytes <= HEAP_BYTES_W'(65536);
            r_rebuild    <= 1'b1;
        end else begin
            r_rebuild <= wr_hit;
            if (wr_hit) begin
                unique case (paddr[2])
                    REG_HEAP_BASE:  r_heap_base  <= pwdata;
                    REG_HEAP_BYTES: r_heap_bytes <= pwdata[HEAP_BYTES_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[2])
            REG_HEAP_BASE:  prdata = r_heap_base;
            REG_HEAP_BYTES: prdata = {{(32-HEAP_BYTES_W){1'b0}}, r_heap_bytes};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = '{heap_base: r_heap_base, heap_bytes: r_heap_bytes, rebuild: r_rebuild};

endmodule
